// ----- rtl/kvt_pkg.sv -----
// Shared constants and types for the key/value table.
package kvt_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_UPSERT = 2'd2;
  localparam logic [1:0] REQ_INSERT = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic clr_we;   // clear the valid mark at the sweep address
    logic load;     // capture a request and restart the search
    logic rd_en;    // read all stores at the sweep address
    logic commit;   // apply the update and load the result register
  } kvt_cmd_t;

endpackage

// ----- rtl/key_value_table_top.sv -----
// Top level of the associative key/value table with stream ports.
// A request passes the scan, drain and decide states; decide holds
// while a result waits on out_tready. The next request is taken only
// after a commit. The scan reads the entry stores through their
// single read port, one entry per cycle. Reset: a sweep clears the
// valid store; in_tready is low until it ends. Keys, values kept.
module key_value_table_top #(
  parameter int ENTRIES = kvt_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] key, [63:32] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_value
  output logic [2:0]  out_tuser   // [0] found, [2:1] status
);

  localparam int IDX_W = $clog2(ENTRIES);

  kvt_pkg::kvt_cmd_t cmd;
  logic [IDX_W-1:0]  addr;
  logic              found;
  logic [1:0]        status;

  kvt_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .addr      (addr)
  );

  kvt_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr      (addr),
    .req_type  (in_tuser),
    .req_key   (in_tdata[31:0]),
    .req_value (in_tdata[63:32]),
    .found     (found),
    .read_value(out_tdata),
    .status    (status)
  );

  assign out_tuser = {status, found};

  // One request in flight: no transaction directly after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed result not presented");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[2:1] == kvt_pkg::ST_DONE))
    else $error("hit reported with a failure status");

  a_miss_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("read data on a miss");

endmodule

// ----- rtl/kvt_dp.sv -----
// Datapath: entry stores, sequential key search and result register.
module kvt_dp #(
  parameter int ENTRIES = kvt_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kvt_pkg::kvt_cmd_t          cmd,
  input  logic [$clog2(ENTRIES)-1:0] addr,
  input  logic [1:0]                 req_type,
  input  logic [kvt_pkg::KEY_W-1:0]  req_key,
  input  logic [kvt_pkg::VAL_W-1:0]  req_value,
  output logic                       found,
  output logic [kvt_pkg::VAL_W-1:0]  read_value,
  output logic [1:0]                 status
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [kvt_pkg::KEY_W-1:0] key_mem [ENTRIES];
  logic [kvt_pkg::VAL_W-1:0] val_mem [ENTRIES];
  logic                      vld_mem [ENTRIES];

  logic [1:0]                type_r;
  logic [kvt_pkg::KEY_W-1:0] key_r;
  logic [kvt_pkg::VAL_W-1:0] value_r;

  logic [kvt_pkg::KEY_W-1:0] key_q_r;
  logic [kvt_pkg::VAL_W-1:0] val_q_r;
  logic                      vld_q_r;
  logic [IDX_W-1:0]          addr_q_r;
  logic                      cmp_en_r;

  logic                      hit_r;
  logic [IDX_W-1:0]          hit_idx_r;
  logic [kvt_pkg::VAL_W-1:0] hit_val_r;
  logic                      free_r;
  logic [IDX_W-1:0]          free_idx_r;

  logic                      found_r;
  logic [kvt_pkg::VAL_W-1:0] rdval_r;
  logic [1:0]                status_r;

  logic                      found_nxt;
  logic [kvt_pkg::VAL_W-1:0] rdval_nxt;
  logic [1:0]                status_nxt;
  logic                      kv_we;
  logic                      val_we;
  logic                      vld_we;
  logic                      vld_wd;
  logic [IDX_W-1:0]          wr_addr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r  <= req_type;
      key_r   <= req_key;
      value_r <= req_value;
    end
  end

  // Registered reads from all three stores
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      key_q_r  <= key_mem[addr];
      val_q_r  <= val_mem[addr];
      vld_q_r  <= vld_mem[addr];
      addr_q_r <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.rd_en;
    end
  end

  // Track the matching entry and the lowest free slot as the sweep passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmp_en_r) begin
      if (vld_q_r && (key_q_r == key_r)) begin
        hit_r <= 1'b1;
      end
      if (!vld_q_r && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en_r) begin
      if (vld_q_r && (key_q_r == key_r)) begin
        hit_idx_r <= addr_q_r;
        hit_val_r <= val_q_r;
      end
      if (!vld_q_r && !free_r) begin
        free_idx_r <= addr_q_r;
      end
    end
  end

  always_comb begin
    found_nxt  = hit_r;
    rdval_nxt  = '0;
    status_nxt = kvt_pkg::ST_DONE;
    kv_we      = 1'b0;
    val_we     = 1'b0;
    vld_we     = 1'b0;
    vld_wd     = 1'b0;
    wr_addr    = hit_r ? hit_idx_r : free_idx_r;
    unique case (type_r)
      kvt_pkg::REQ_LOOKUP: begin
        if (hit_r) begin
          rdval_nxt = hit_val_r;
        end else begin
          status_nxt = kvt_pkg::ST_NOTFOUND;
        end
      end
      kvt_pkg::REQ_DELETE: begin
        if (hit_r) begin
          vld_we = 1'b1;
        end else begin
          status_nxt = kvt_pkg::ST_NOTFOUND;
        end
      end
      kvt_pkg::REQ_UPSERT, kvt_pkg::REQ_INSERT: begin
        if (hit_r) begin
          val_we = (type_r == kvt_pkg::REQ_UPSERT);
        end else if (free_r) begin
          kv_we  = 1'b1;
          val_we = 1'b1;
          vld_we = 1'b1;
          vld_wd = 1'b1;
        end else begin
          status_nxt = kvt_pkg::ST_FULL;
        end
      end
      default: begin
        status_nxt = kvt_pkg::ST_DONE;
      end
    endcase
    kv_we  = kv_we && cmd.commit;
    val_we = val_we && cmd.commit;
    vld_we = vld_we && cmd.commit;
    // Reset sweep owns the valid store write port
    if (cmd.clr_we) begin
      vld_we  = 1'b1;
      vld_wd  = 1'b0;
      wr_addr = addr;
    end
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[wr_addr] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[wr_addr] <= vld_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found_r  <= found_nxt;
      rdval_r  <= rdval_nxt;
      status_r <= status_nxt;
    end
  end

  assign found      = found_r;
  assign read_value = rdval_r;
  assign status     = status_r;

endmodule

// ----- rtl/kvt_ctrl.sv -----
// Controller: reset sweep, entry scan sequencing and stream handshakes.
module kvt_ctrl #(
  parameter int ENTRIES = kvt_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output kvt_pkg::kvt_cmd_t          cmd,
  output logic [$clog2(ENTRIES)-1:0] addr
);

  localparam int               IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(ENTRIES - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (addr_r == LAST) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          addr_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (addr_r == LAST) begin
          addr_nxt  = '0;
          state_nxt = S_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        addr_nxt  = '0;
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign addr       = addr_r;

endmodule
